// ===== hw/rtl/fexp_pkg.sv =====
package fexp_pkg;

    // cells in the row: x*R, two reduction steps, six Horner steps, final scale
    localparam int NUM_CELLS   = 10;
    localparam int HORNER_BASE = 4;
    localparam int HORNER_TAIL = 5;

    localparam logic [31:0] EXP_LB_BITS  = 32'hC2CF_F1B5;
    localparam logic [31:0] EXP_UB_BITS  = 32'h42B1_7218;
    localparam logic [31:0] EXP_R_BITS   = 32'h3FB8_AA3B;
    localparam logic [31:0] NEG_C1_BITS  = 32'hBF31_7200;
    localparam logic [31:0] NEG_C2_BITS  = 32'hB5BF_BE8E;
    localparam logic [31:0] EXP_P6_BITS  = 32'h3AB4_2872;
    localparam logic [31:0] EXP_P5_BITS  = 32'h3C09_1DE6;
    localparam logic [31:0] EXP_P4_BITS  = 32'h3D2A_ADCC;
    localparam logic [31:0] EXP_P3_BITS  = 32'h3E2A_AA47;
    localparam logic [31:0] EXP_P2_BITS  = 32'h3EFF_FFFC;
    localparam logic [31:0] ONE_BITS     = 32'h3F80_0000;
    localparam logic [31:0] QNAN_BITS    = 32'h7FC0_0000;
    localparam logic [31:0] POS_ZERO     = 32'h0000_0000;

    // addends of the Horner steps after the first one
    localparam logic [31:0] HORNER_C [HORNER_TAIL] = '{
        EXP_P4_BITS, EXP_P3_BITS, EXP_P2_BITS, ONE_BITS, ONE_BITS
    };

    typedef struct packed {
        logic        last;
        logic        nan;
        logic [31:0] x;
        logic [31:0] z;
        logic [31:0] s;
        logic [15:0] q;
    } side_t;

endpackage

// ===== hw/rtl/fexp_in_if.sv =====
interface fexp_in_if;
    logic        valid;
    logic        ready;
    logic [31:0] x_bits;
    logic        last_in;

    modport source (output valid, output x_bits, output last_in, input ready);
    modport sink (input valid, input x_bits, input last_in, output ready);
endinterface

// ===== hw/rtl/fexp_out_if.sv =====
interface fexp_out_if;
    logic        valid;
    logic        ready;
    logic [31:0] exp_bits;
    logic        last_out;

    modport source (output valid, output exp_bits, output last_out, input ready);
    modport sink (input valid, input exp_bits, input last_out, output ready);
endinterface

// ===== hw/rtl/fexp_fma_cell.sv =====
module fexp_fma_cell
    import fexp_pkg::*;
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        en,
    input  logic        in_valid,
    input  logic [31:0] a,
    input  logic [31:0] b,
    input  logic [31:0] c,
    input  side_t       side_in,
    output logic        out_valid,
    output logic [31:0] res,
    output side_t       side_out
);

    function automatic logic [6:0] lzc78(input logic [77:0] v);
        logic [6:0] n;
        n = 7'd78;
        for (int i = 0; i < 78; i++)
        begin
            if (v[i])
            begin
                n = 7'(77 - i);
            end
        end
        return n;
    endfunction

    logic v1_reg, v2_reg, v3_reg, v4_reg, v5_reg, v6_reg;
    side_t side1_reg, side2_reg, side3_reg, side4_reg, side5_reg, side6_reg;

    // stage 1: unpack and multiply
    logic [7:0]  ea, eb, ec;
    logic [23:0] ma, mb, mc;
    logic [47:0] prod_next;
    logic signed [10:0] ep_next, ec_next;
    logic [47:0] p_reg;
    logic [23:0] mc_reg;
    logic signed [10:0] ep_reg, ec_reg;
    logic sp1_reg, sc1_reg;

    always_comb
    begin
        ea = (a[30:23] == 8'd0) ? 8'd1 : a[30:23];
        eb = (b[30:23] == 8'd0) ? 8'd1 : b[30:23];
        ec = (c[30:23] == 8'd0) ? 8'd1 : c[30:23];
        ma = {|a[30:23], a[22:0]};
        mb = {|b[30:23], b[22:0]};
        mc = {|c[30:23], c[22:0]};
        prod_next = ma * mb;
        ep_next = $signed({3'b000, ea}) + $signed({3'b000, eb}) - 11'sd300;
        ec_next = $signed({3'b000, ec}) - 11'sd150;
    end

    // stage 2: align the addend against the product and add
    logic signed [10:0] sh, nsh, e0_next;
    logic        pz, sat, lost_c;
    logic [23:0] crs;
    logic [76:0] pf, cf;
    logic [78:0] r_next;
    logic [78:0] r_reg;
    logic signed [10:0] e0_reg;
    logic sp2_reg, sc2_reg;

    always_comb
    begin
        sh     = ec_reg - ep_reg + 11'sd3;
        nsh    = -sh;
        pz     = (p_reg == 48'd0);
        sat    = pz || (sh > 11'sd53);
        crs    = 24'd0;
        lost_c = 1'b0;
        if (nsh > 11'sd25)
        begin
            lost_c = |mc_reg;
        end
        else
        begin
            crs    = mc_reg >> nsh[4:0];
            lost_c = |(mc_reg & ((24'd1 << nsh[4:0]) - 24'd1));
        end
        if (sat)
        begin
            pf = {76'd0, !pz};
            cf = {mc_reg, 53'd0};
            e0_next = ec_reg - 11'sd53;
        end
        else
        begin
            pf = {26'd0, p_reg, 3'b000};
            e0_next = ep_reg - 11'sd3;
            if (sh >= 11'sd0)
            begin
                cf = 77'(mc_reg) << sh[5:0];
            end
            else
            begin
                // bits shifted out below the frame are jammed into its lsb
                cf = {53'd0, crs[23:1], crs[0] | lost_c};
            end
        end
        if (sp1_reg == sc1_reg)
        begin
            r_next = {2'b00, pf} + {2'b00, cf};
        end
        else
        begin
            r_next = {2'b00, pf} - {2'b00, cf};
        end
    end

    // stage 3: magnitude
    logic [77:0] mag_next, mag3_reg;
    logic signed [10:0] epre3_reg;
    logic sign3_reg, sz3_reg;

    always_comb
    begin
        mag_next = r_reg[78] ? (~r_reg[77:0] + 78'd1) : r_reg[77:0];
    end

    // stage 4: leading zero count
    logic [77:0] mag4_reg;
    logic [6:0]  lz4_reg;
    logic signed [10:0] epre4_reg;
    logic sign4_reg, sz4_reg, zero4_reg;

    // stage 5: normalise, work out exponent and denormal shift
    logic [77:0] norm;
    logic signed [10:0] e5, k5;
    logic [4:0]  k_next;
    logic [7:0]  ef_next;
    logic [24:0] top5_reg;
    logic        st5_reg, ovf5_reg, sign5_reg, sz5_reg, zero5_reg;
    logic [4:0]  k5_reg;
    logic [7:0]  ef5_reg;

    always_comb
    begin
        norm = mag4_reg << lz4_reg;
        e5   = epre4_reg - $signed({4'b0000, lz4_reg});
        k5   = 11'sd1 - e5;
        if (e5 >= 11'sd1)
        begin
            k_next  = 5'd0;
            ef_next = e5[7:0];
        end
        else if (e5 < -11'sd24)
        begin
            k_next  = 5'd26;
            ef_next = 8'd0;
        end
        else
        begin
            k_next  = k5[4:0];
            ef_next = 8'd0;
        end
    end

    // stage 6: denormal shift and round to nearest even
    logic [24:0] tsh;
    logic        lost_t, st_all, inc;
    logic [23:0] mant;
    logic [30:0] pk;
    logic [31:0] res_next, res_reg;

    always_comb
    begin
        tsh    = top5_reg >> k5_reg;
        lost_t = |(top5_reg & ((25'd1 << k5_reg) - 25'd1));
        st_all = st5_reg | lost_t;
        mant   = tsh[24:1];
        inc    = tsh[0] & (st_all | mant[0]);
        // a carry out of the fraction steps the exponent field
        pk     = {ef5_reg, mant[22:0]} + 31'(inc);
        if (zero5_reg)
        begin
            res_next = {sz5_reg, 31'd0};
        end
        else if (ovf5_reg)
        begin
            res_next = {sign5_reg, 8'hFF, 23'd0};
        end
        else
        begin
            res_next = {sign5_reg, pk};
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            v1_reg <= 1'b0;
            v2_reg <= 1'b0;
            v3_reg <= 1'b0;
            v4_reg <= 1'b0;
            v5_reg <= 1'b0;
            v6_reg <= 1'b0;
        end
        else if (en)
        begin
            v1_reg <= in_valid;
            v2_reg <= v1_reg;
            v3_reg <= v2_reg;
            v4_reg <= v3_reg;
            v5_reg <= v4_reg;
            v6_reg <= v5_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            side1_reg <= side_in;
            p_reg     <= prod_next;
            mc_reg    <= mc;
            ep_reg    <= ep_next;
            ec_reg    <= ec_next;
            sp1_reg   <= a[31] ^ b[31];
            sc1_reg   <= c[31];

            side2_reg <= side1_reg;
            r_reg     <= r_next;
            e0_reg    <= e0_next;
            sp2_reg   <= sp1_reg;
            sc2_reg   <= sc1_reg;

            side3_reg <= side2_reg;
            mag3_reg  <= mag_next;
            epre3_reg <= e0_reg + 11'sd204;
            sign3_reg <= sp2_reg ^ r_reg[78];
            sz3_reg   <= sp2_reg & sc2_reg;

            side4_reg <= side3_reg;
            mag4_reg  <= mag3_reg;
            lz4_reg   <= lzc78(mag3_reg);
            epre4_reg <= epre3_reg;
            sign4_reg <= sign3_reg;
            sz4_reg   <= sz3_reg;
            zero4_reg <= (mag3_reg == 78'd0);

            side5_reg <= side4_reg;
            top5_reg  <= norm[77:53];
            st5_reg   <= |norm[52:0];
            k5_reg    <= k_next;
            ef5_reg   <= ef_next;
            ovf5_reg  <= (e5 > 11'sd254);
            sign5_reg <= sign4_reg;
            sz5_reg   <= sz4_reg;
            zero5_reg <= zero4_reg;

            side6_reg <= side5_reg;
            res_reg   <= res_next;
        end
    end

    assign out_valid = v6_reg;
    assign res       = res_reg;
    assign side_out  = side6_reg;

endmodule

// ===== hw/rtl/fexp_qconv.sv =====
module fexp_qconv
    import fexp_pkg::*;
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        en,
    input  logic        in_valid,
    input  logic [31:0] v,
    input  side_t       side_in,
    output logic        out_valid,
    output side_t       side_out
);

    logic [7:0]  ev;
    logic [23:0] mv;
    logic [3:0]  fsh;
    logic [38:0] fx;
    logic [14:0] ip;
    logic        rnd;
    logic [15:0] qmag, q_next;
    side_t       s1_next, s1_reg, s2_next, s2_reg;
    logic        v1_reg, v2_reg;

    // round half to even into a saturated 16-bit integer
    always_comb
    begin
        ev   = v[30:23];
        mv   = {|ev, v[22:0]};
        fsh  = 4'(ev - 8'd126);
        fx   = 39'(mv) << fsh;
        ip   = fx[38:24];
        rnd  = fx[23] & ((|fx[22:0]) | ip[0]);
        qmag = {1'b0, ip} + 16'(rnd);
        if (side_in.nan || ev < 8'd126)
        begin
            q_next = 16'd0;
        end
        else if (ev >= 8'd142)
        begin
            q_next = v[31] ? 16'h8000 : 16'h7FFF;
        end
        else if (v[31])
        begin
            q_next = -qmag;
        end
        else
        begin
            q_next = qmag[15] ? 16'h7FFF : qmag;
        end
        s1_next   = side_in;
        s1_next.q = q_next;
    end

    logic [16:0] zmag;
    logic [4:0]  pos;
    logic [39:0] zsh;

    // exact int to float of q
    always_comb
    begin
        zmag = s1_reg.q[15] ? (17'd0 - {1'b1, s1_reg.q}) : {1'b0, s1_reg.q};
        pos  = 5'd0;
        for (int i = 0; i < 17; i++)
        begin
            if (zmag[i])
            begin
                pos = 5'(i);
            end
        end
        zsh = {23'd0, zmag} << (5'd23 - pos);
        s2_next = s1_reg;
        if (zmag == 17'd0)
        begin
            s2_next.z = POS_ZERO;
        end
        else
        begin
            s2_next.z = {s1_reg.q[15], 8'd127 + {3'b000, pos}, zsh[22:0]};
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            v1_reg <= 1'b0;
            v2_reg <= 1'b0;
        end
        else if (en)
        begin
            v1_reg <= in_valid;
            v2_reg <= v1_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            s1_reg <= s1_next;
            s2_reg <= s2_next;
        end
    end

    assign out_valid = v2_reg;
    assign side_out  = s2_reg;

endmodule

// ===== hw/rtl/float32_exp_unit.sv =====
// Elementwise exp() on IEEE single precision values.
// din carries x_bits and last_in, dout carries exp_bits and last_out; both are
// valid/ready channels and a transaction moves on a clock edge where valid and
// ready are high. Every input transaction gives exactly one output transaction,
// in order, with last_out a copy of last_in.
// The datapath is a row of ten fused multiply-add cells (x*R, two reduction
// steps, six Horner steps, final scale by 2^q), each six stages deep, with an
// input register, a clamp stage, two stages that round x*R to q and convert it
// back, and one stage that splits 2^q into two factors.
// Throughput is one item per cycle while din.ready is high; the whole row
// advances together. When dout stalls, one more result is caught in a skid
// register and the row then holds; din.ready is low while the skid register
// is full, so din.ready never depends combinationally on dout.ready.
// Reset clears all valid flags; the row is empty and din.ready is high after it.
// A NaN input gives 0x7FC00000; infinities are clamped like finite values.
module float32_exp_unit
    import fexp_pkg::*;
(
    input  logic              clk,
    input  logic              rst_n,
    fexp_in_if.sink           din,
    fexp_out_if.source        dout
);

    logic en;

    logic        a_valid_reg;
    logic [31:0] a_x_reg;
    logic        a_last_reg;

    logic        b_valid_reg;
    side_t       b_side_reg;
    side_t       b_side_next;
    logic        x_nan;

    logic        cell_in_valid  [NUM_CELLS];
    logic [31:0] cell_a         [NUM_CELLS];
    logic [31:0] cell_b         [NUM_CELLS];
    logic [31:0] cell_c         [NUM_CELLS];
    side_t       cell_side_in   [NUM_CELLS];
    logic        cell_out_valid [NUM_CELLS];
    logic [31:0] cell_res       [NUM_CELLS];
    side_t       cell_side_out  [NUM_CELLS];

    logic        q_valid;
    side_t       q_side;

    logic        t_valid_reg;
    logic [31:0] t_tb_reg, t_rb_reg;
    side_t       t_side_reg;
    logic [15:0] lo, hi;

    logic        fin_valid;
    logic [31:0] fin_exp;
    logic        fin_last;

    logic        out_valid_reg, skid_valid_reg;
    logic [31:0] out_exp_reg, skid_exp_reg;
    logic        out_last_reg, skid_last_reg;

    assign en        = !skid_valid_reg;
    assign din.ready = en;

    // clamp to [LB, UB]; NaN goes through as zero and is patched at the end
    always_comb
    begin
        x_nan = (a_x_reg[30:23] == 8'hFF) && (a_x_reg[22:0] != 23'd0);
        b_side_next      = '0;
        b_side_next.last = a_last_reg;
        b_side_next.nan  = x_nan;
        if (x_nan)
        begin
            b_side_next.x = POS_ZERO;
        end
        else if (a_x_reg[31] && a_x_reg[30:0] > EXP_LB_BITS[30:0])
        begin
            b_side_next.x = EXP_LB_BITS;
        end
        else if (!a_x_reg[31] && a_x_reg[30:0] > EXP_UB_BITS[30:0])
        begin
            b_side_next.x = EXP_UB_BITS;
        end
        else
        begin
            b_side_next.x = a_x_reg;
        end
    end

    always_comb
    begin
        cell_in_valid[0] = b_valid_reg;
        cell_a[0]        = b_side_reg.x;
        cell_b[0]        = EXP_R_BITS;
        cell_c[0]        = POS_ZERO;
        cell_side_in[0]  = b_side_reg;

        cell_in_valid[1] = q_valid;
        cell_a[1]        = NEG_C1_BITS;
        cell_b[1]        = q_side.z;
        cell_c[1]        = q_side.x;
        cell_side_in[1]  = q_side;

        cell_in_valid[2] = cell_out_valid[1];
        cell_a[2]        = NEG_C2_BITS;
        cell_b[2]        = cell_side_out[1].z;
        cell_c[2]        = cell_res[1];
        cell_side_in[2]  = cell_side_out[1];

        cell_in_valid[3] = cell_out_valid[2];
        cell_a[3]        = EXP_P6_BITS;
        cell_b[3]        = cell_res[2];
        cell_c[3]        = EXP_P5_BITS;
        cell_side_in[3]  = cell_side_out[2];
        cell_side_in[3].s = cell_res[2];

        for (int i = HORNER_BASE; i < HORNER_BASE + HORNER_TAIL; i++)
        begin
            cell_in_valid[i] = cell_out_valid[i-1];
            cell_a[i]        = cell_res[i-1];
            cell_b[i]        = cell_side_out[i-1].s;
            cell_c[i]        = HORNER_C[i-HORNER_BASE];
            cell_side_in[i]  = cell_side_out[i-1];
        end

        cell_in_valid[NUM_CELLS-1] = t_valid_reg;
        cell_a[NUM_CELLS-1]        = t_tb_reg;
        cell_b[NUM_CELLS-1]        = t_rb_reg;
        cell_c[NUM_CELLS-1]        = POS_ZERO;
        cell_side_in[NUM_CELLS-1]  = t_side_reg;
    end

    for (genvar g = 0; g < NUM_CELLS; g++)
    begin : g_cell
        fexp_fma_cell u_cell (
            .clk       (clk),
            .rst_n     (rst_n),
            .en        (en),
            .in_valid  (cell_in_valid[g]),
            .a         (cell_a[g]),
            .b         (cell_b[g]),
            .c         (cell_c[g]),
            .side_in   (cell_side_in[g]),
            .out_valid (cell_out_valid[g]),
            .res       (cell_res[g]),
            .side_out  (cell_side_out[g])
        );
    end

    fexp_qconv u_qconv (
        .clk       (clk),
        .rst_n     (rst_n),
        .en        (en),
        .in_valid  (cell_out_valid[0]),
        .v         (cell_res[0]),
        .side_in   (cell_side_out[0]),
        .out_valid (q_valid),
        .side_out  (q_side)
    );

    // 2^q split as 2^hi folded into the exponent field and 2^lo as a factor
    always_comb
    begin
        lo = {cell_side_out[NUM_CELLS-2].q[15], cell_side_out[NUM_CELLS-2].q[15:1]};
        hi = lo + 16'(cell_side_out[NUM_CELLS-2].q[0]);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            a_valid_reg <= 1'b0;
            b_valid_reg <= 1'b0;
            t_valid_reg <= 1'b0;
        end
        else if (en)
        begin
            a_valid_reg <= din.valid;
            b_valid_reg <= a_valid_reg;
            t_valid_reg <= cell_out_valid[NUM_CELLS-2];
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            a_x_reg    <= din.x_bits;
            a_last_reg <= din.last_in;
            b_side_reg <= b_side_next;
            t_tb_reg   <= cell_res[NUM_CELLS-2] + {hi[8:0], 23'd0};
            t_rb_reg   <= ONE_BITS + {lo[8:0], 23'd0};
            t_side_reg <= cell_side_out[NUM_CELLS-2];
        end
    end

    assign fin_valid = cell_out_valid[NUM_CELLS-1];
    assign fin_exp   = cell_side_out[NUM_CELLS-1].nan ? QNAN_BITS : cell_res[NUM_CELLS-1];
    assign fin_last  = cell_side_out[NUM_CELLS-1].last;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg  <= 1'b0;
            skid_valid_reg <= 1'b0;
        end
        else if (en && fin_valid)
        begin
            if (out_valid_reg && !dout.ready)
            begin
                skid_valid_reg <= 1'b1;
            end
            else
            begin
                out_valid_reg <= 1'b1;
            end
        end
        else if (dout.ready)
        begin
            if (skid_valid_reg)
            begin
                skid_valid_reg <= 1'b0;
            end
            else
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (en && fin_valid)
        begin
            if (out_valid_reg && !dout.ready)
            begin
                skid_exp_reg  <= fin_exp;
                skid_last_reg <= fin_last;
            end
            else
            begin
                out_exp_reg  <= fin_exp;
                out_last_reg <= fin_last;
            end
        end
        else if (dout.ready && skid_valid_reg)
        begin
            out_exp_reg  <= skid_exp_reg;
            out_last_reg <= skid_last_reg;
        end
    end

    assign dout.valid    = out_valid_reg;
    assign dout.exp_bits = out_exp_reg;
    assign dout.last_out = out_last_reg;

    a_skid_needs_out: assert property (@(posedge clk) disable iff (!rst_n)
        skid_valid_reg |-> out_valid_reg)
        else $error("skid register full while output register empty");

    a_skid_fill_cause: assert property (@(posedge clk) disable iff (!rst_n)
        $rose(skid_valid_reg) |-> $past(out_valid_reg && !dout.ready))
        else $error("skid register filled without an output stall");

    a_stall_capture: assert property (@(posedge clk) disable iff (!rst_n)
        (en && fin_valid && out_valid_reg && !dout.ready) |=> skid_valid_reg)
        else $error("result leaving the row during a stall was not caught");

endmodule

// ===== dv/float32_exp_unit_tb.sv =====
module float32_exp_unit_tb;
    import fexp_pkg::*;

    logic clk;
    logic rst_n;
    int   errors;
    int   idle_cycles;
    bit   calm;

    fexp_in_if  din_if ();
    fexp_out_if dout_if ();

    float32_exp_unit i_dut (
        .clk   (clk),
        .rst_n (rst_n),
        .din   (din_if),
        .dout  (dout_if)
    );

    initial clk = 1'b0;
    always #6 clk = ~clk;

    // binary32 bits to double, exact
    function automatic real f32_to_real(input logic [31:0] b);
        real r;
        if (b[30:23] == 8'd0)
        begin
            r = real'(b[22:0]) * (2.0 ** (-149));
            return b[31] ? -r : r;
        end
        if (b[30:23] == 8'hff)
            return $bitstoreal({b[31], 11'h7ff, 52'd0});
        return $bitstoreal({b[31], 11'(int'(b[30:23]) - 127 + 1023), b[22:0], 29'd0});
    endfunction

    // double to binary32 with round to nearest even, subnormals and overflow
    function automatic logic [31:0] real_to_f32(input real d);
        logic [63:0] w;
        logic [63:0] sig;
        logic [63:0] kept;
        logic [63:0] rem;
        logic [63:0] half;
        logic [63:0] mag;
        int          fe;
        int          sh;
        w = $realtobits(d);
        if (w[62:52] == 11'h7ff)
            return {w[63], 31'h7f80_0000};
        if (w[62:52] == 11'd0)
            return {w[63], 31'd0};
        fe  = int'(w[62:52]) - 1023 + 127;
        if (fe >= 255)
            return {w[63], 31'h7f80_0000};
        sig = {11'd0, 1'b1, w[51:0]};
        sh  = (fe >= 1) ? 29 : 29 + 1 - fe;
        if (sh >= 55)
            return {w[63], 31'd0};
        kept = sig >> sh;
        rem  = sig & ((64'd1 << sh) - 64'd1);
        half = 64'd1 << (sh - 1);
        if (rem > half || (rem == half && kept[0]))
            kept = kept + 64'd1;
        // the hidden bit carries into the exponent field
        mag = (fe >= 1) ? (64'(fe - 1) << 23) + kept : kept;
        if (mag >= 64'h7f80_0000)
            mag = 64'h7f80_0000;
        return {w[63], mag[30:0]};
    endfunction

    function automatic logic [31:0] fmul32(input logic [31:0] a, input logic [31:0] b);
        return real_to_f32(f32_to_real(a) * f32_to_real(b));
    endfunction

    // a*b+c with one rounding: sum rounded to odd in double first
    function automatic logic [31:0] fma32(input logic [31:0] a, input logic [31:0] b,
                                          input logic [31:0] c);
        real         p;
        real         cc;
        real         s;
        real         bv;
        real         e;
        logic [63:0] w;
        p  = f32_to_real(a) * f32_to_real(b);
        cc = f32_to_real(c);
        s  = p + cc;
        bv = s - p;
        e  = (p - (s - bv)) + (cc - bv);
        if (e != 0.0)
        begin
            w = $realtobits(s);
            if (!w[0])
            begin
                if ((e > 0.0) == (s > 0.0))
                    w = w + 64'd1;
                else
                    w = w - 64'd1;
                s = $bitstoreal(w);
            end
        end
        return real_to_f32(s);
    endfunction

    function automatic int round_q16(input real d);
        int  t;
        real fr;
        if (d > 32767.0)
            return 32767;
        if (d < -32768.0)
            return -32768;
        t  = $rtoi(d);
        fr = d - real'(t);
        if (fr > 0.5 || (fr == 0.5 && t[0]))
            t = t + 1;
        else if (fr < -0.5 || (fr == -0.5 && t[0]))
            t = t - 1;
        if (t > 32767)
            t = 32767;
        if (t < -32768)
            t = -32768;
        return t;
    endfunction

    function automatic logic [31:0] exp_f32(input logic [31:0] x_in);
        logic [31:0] x;
        logic [31:0] z;
        logic [31:0] s;
        logic [31:0] u;
        logic [31:0] tb;
        logic [31:0] rb;
        int          q;
        int          lo;
        int          hi;
        x = x_in;
        if (x[30:23] == 8'hff && x[22:0] != 23'd0)
            return QNAN_BITS;
        if (f32_to_real(x) < f32_to_real(EXP_LB_BITS))
            x = EXP_LB_BITS;
        if (f32_to_real(x) > f32_to_real(EXP_UB_BITS))
            x = EXP_UB_BITS;
        q = round_q16(f32_to_real(fmul32(x, EXP_R_BITS)));
        z = real_to_f32(real'(q));
        s = fma32(NEG_C1_BITS, z, x);
        s = fma32(NEG_C2_BITS, z, s);
        u = fma32(EXP_P6_BITS, s, EXP_P5_BITS);
        u = fma32(u, s, EXP_P4_BITS);
        u = fma32(u, s, EXP_P3_BITS);
        u = fma32(u, s, EXP_P2_BITS);
        u = fma32(u, s, ONE_BITS);
        u = fma32(u, s, ONE_BITS);
        lo = (q - (q & 1)) / 2;
        hi = (q + (q & 1)) / 2;
        tb = u + 32'(hi) * 32'h0080_0000;
        rb = ONE_BITS + 32'(lo) * 32'h0080_0000;
        return fmul32(tb, rb);
    endfunction

    class exp_scoreboard;
        typedef struct {
            logic [31:0] value;
            logic        last;
        } exp_result_t;

        exp_result_t pending[$];
        int          mismatches;

        function void note_input(input logic [31:0] x, input logic last);
            exp_result_t r;
            r.value = exp_f32(x);
            r.last  = last;
            pending.push_back(r);
        endfunction

        function void check_result(input logic [31:0] value, input logic last);
            exp_result_t r;
            if (pending.size() == 0)
            begin
                $display("%0t: unexpected result exp_bits=%h last_out=%b", $time, value, last);
                mismatches++;
                return;
            end
            r = pending.pop_front();
            if (value !== r.value)
            begin
                $display("%0t: exp_bits expected %h actual %h", $time, r.value, value);
                mismatches++;
            end
            if (last !== r.last)
            begin
                $display("%0t: last_out expected %b actual %b", $time, r.last, last);
                mismatches++;
            end
        endfunction
    endclass

    exp_scoreboard exp_sb;

    function automatic int pick_gap();
        int r;
        if (calm)
            return 0;
        r = $urandom_range(0, 99);
        if (r < 55)
            return 0;
        if (r < 85)
            return $urandom_range(1, 3);
        if (r < 97)
            return $urandom_range(4, 12);
        return $urandom_range(20, 60);
    endfunction

    // called at a falling edge, returns at the falling edge after the transaction
    task automatic send_item(input logic [31:0] x, input logic last);
        int gap;
        gap = pick_gap();
        repeat (gap)
        begin
            din_if.valid <= 1'b0;
            @(negedge clk);
        end
        din_if.valid   <= 1'b1;
        din_if.x_bits  <= x;
        din_if.last_in <= last;
        do
            @(posedge clk);
        while (!din_if.ready);
        exp_sb.note_input(x, last);
        @(negedge clk);
    endtask

    // mostly finite values across the useful range, some raw patterns
    function automatic logic [31:0] random_x();
        int r;
        r = $urandom_range(0, 99);
        if (r < 15)
            return $urandom();
        if (r < 25)
            return {1'b1, 8'(133), 23'($urandom())};
        return {1'($urandom()), 8'($urandom_range(100, 133)), 23'($urandom())};
    endfunction

    logic [31:0] directed_x[] = '{
        32'h7FC0_0000, 32'hFF80_0001, 32'h7F80_0001, 32'hFFFF_FFFF,
        32'h7F80_0000, 32'hFF80_0000, 32'h0000_0000, 32'h8000_0000,
        32'h0000_0001, 32'h807F_FFFF, 32'h7F7F_FFFF, 32'hFF7F_FFFF,
        EXP_LB_BITS,   EXP_UB_BITS,   32'h42B1_7217, 32'h42B1_7219,
        32'hC2CF_F1B4, 32'hC2CF_F1B6, 32'h3F80_0000, 32'hBF80_0000,
        32'hC2AE_AC50, 32'hC2C8_0000, 32'h3F31_7218, 32'h4000_0000
    };

    int stall_left;

    always @(negedge clk)
    begin
        if (stall_left > 0)
        begin
            dout_if.ready <= 1'b0;
            stall_left--;
        end
        else
        begin
            dout_if.ready <= 1'b1;
            stall_left = pick_gap();
        end
    end

    always @(posedge clk)
    begin
        if (rst_n)
        begin
            if (dout_if.valid && dout_if.ready)
                exp_sb.check_result(dout_if.exp_bits, dout_if.last_out);
            if ((dout_if.valid && dout_if.ready) || (din_if.valid && din_if.ready))
                idle_cycles = 0;
            else
                idle_cycles++;
            if (idle_cycles >= 2000)
            begin
                $display("%0t: watchdog expired", $time);
                $display("*** FAILED ***");
                $finish;
            end
        end
    end

    initial
    begin
        exp_sb         = new();
        idle_cycles    = 0;
        stall_left     = 0;
        calm           = 1'b0;
        rst_n          = 1'b0;
        din_if.valid   = 1'b0;
        din_if.x_bits  = 32'd0;
        din_if.last_in = 1'b0;
        dout_if.ready  = 1'b0;
        repeat (6) @(negedge clk);
        rst_n = 1'b1;
        @(negedge clk);

        foreach (directed_x[i])
            send_item(directed_x[i], i == directed_x.size() - 1);

        for (int n = 0; n < 850; n++)
        begin
            if (n % 100 == 0)
                calm = ($urandom_range(0, 2) == 0);
            if (n == 400)
            begin
                // hold the sender until the pipe has drained
                din_if.valid <= 1'b0;
                while (exp_sb.pending.size() != 0)
                    @(negedge clk);
            end
            send_item(random_x(), $urandom_range(0, 15) == 0);
        end
        din_if.valid <= 1'b0;

        while (exp_sb.pending.size() != 0)
            @(posedge clk);
        repeat (80) @(posedge clk);
        errors = exp_sb.mismatches;
        if (errors == 0)
            $display("*** PASSED ***");
        else
            $display("*** FAILED ***");
        $finish;
    end

endmodule
